/* rtl/core/bcsa_pkg.sv */
// Shared types and constants of the contiguous sector allocator.
// No dependencies; imported by the allocator top level.
`default_nettype none

package bcsa_pkg;

   // map word geometry
   localparam int WORD_W = 32;
   localparam int LOG_W  = 5;

   // request field widths
   localparam int FUNC_W  = 2;
   localparam int FIRST_W = 10;
   localparam int RUN_W   = 11;
   localparam int START_W = 10;

   typedef logic [FUNC_W-1:0] func_type;

   localparam func_type FN_ALLOC = 2'd0;
   localparam func_type FN_FREE  = 2'd1;
   localparam func_type FN_CLEAR = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/bcsa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module bcsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/bitmap_contiguous_sector_allocator_unit.sv */
// First-fit contiguous sector allocator over a used-bit map held in RAM.
// Depends on bcsa_pkg and bcsa_ram.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tuser: func; tdata: first_sector, run_length
//  rsp     | out | rsp_tvalid/tready   | tuser: status; tdata: run_start
//
// One request at a time. The map is read one 32-bit word per cycle from RAM.
// Allocate scans map words until one completes a fitting run, then marks the words of the run.
// Free marks the words its range touches. Clear and rejected requests go straight to the result.
// Reset clears a valid bit per map word at once; no clearing pass is needed.
// A waiting result sits in the output register while the next request is taken.
`default_nettype none

module bitmap_contiguous_sector_allocator_unit
   import bcsa_pkg::*;
#(
   parameter int NUM_SECTORS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // [1:0] func
   input  wire logic [23:0] req_tdata,   // [9:0] first_sector, [20:10] run_length, rest zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [0:0]       rsp_tuser,   // [0] status
   output logic [15:0]      rsp_tdata    // [9:0] run_start, rest zero
);

   localparam int WORDS = (NUM_SECTORS + WORD_W - 1) / WORD_W;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int EXT_W = $clog2(NUM_SECTORS + 1024) + 1;
   localparam logic [EXT_W-1:0] NUM_X  = EXT_W'(NUM_SECTORS);
   localparam logic [EXT_W-1:0] LAST_X = EXT_W'(NUM_SECTORS - 1);
   localparam logic [WAW-1:0]   LAST_W = WAW'(WORDS - 1);

   state_type            state_ff, state_in;
   logic [WAW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [WAW-1:0]       ev_ptr_ff;
   logic                 ev_vld_ff, ev_vld_in;
   logic                 rvalid_ff;
   logic [WORDS-1:0]     valid_ff, valid_in;
   logic                 op_set_ff, op_set_in;
   logic [RUN_W-1:0]     len_ff, len_in;
   logic [EXT_W-1:0]     lo_ff, lo_in;
   logic [EXT_W-1:0]     hi_ff, hi_in;
   logic [WAW-1:0]       end_word_ff, end_word_in;
   logic [EXT_W-1:0]     carry_ff, carry_in;
   logic [EXT_W-1:0]     cbegin_ff, cbegin_in;
   logic                 res_status_ff, res_status_in;
   logic [START_W-1:0]   res_start_ff, res_start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]   rsp_start_ff, rsp_start_in;

   // RAM port signals
   logic                 rd_en;
   logic [WORD_W-1:0]    rd_data;
   logic                 wr_en;
   logic [WORD_W-1:0]    wr_data;

   // request fields
   func_type             req_func;
   logic [FIRST_W-1:0]   req_first;
   logic [RUN_W-1:0]     req_len;
   logic [EXT_W-1:0]     free_end;
   logic [EXT_W-1:0]     free_hi;
   logic [EXT_W-1:0]     free_sh;
   logic [EXT_W-1:0]     hi_sh;

   // word evaluation
   logic [EXT_W-1:0]     base;
   logic [WORD_W-1:0]    word;
   logic [WORD_W-1:0]    eff_used;
   logic [WORD_W-1:0]    mask;
   logic [EXT_W-1:0]     run_a   [WORD_W];
   logic [EXT_W-1:0]     begin_a [WORD_W];
   logic [WORD_W-1:0]    hit;
   logic                 hit_any;
   logic [EXT_W-1:0]     hit_begin;
   logic [EXT_W-1:0]     alloc_hi;
   logic [EXT_W-1:0]     alloc_sh;
   logic [EXT_W-1:0]     alloc_lo_sh;

   assign req_func  = req_tuser;
   assign req_first = req_tdata[9:0];
   assign req_len   = req_tdata[20:10];

   assign free_end = EXT_W'(req_first) + EXT_W'(req_len) - EXT_W'(1);
   assign free_hi  = (free_end > LAST_X) ? LAST_X : free_end;
   assign free_sh  = EXT_W'(req_first) >> LOG_W;
   assign hi_sh    = free_hi >> LOG_W;

   bcsa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ev_ptr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // A map word not yet written since reset or clear reads as all free.
   // Sectors beyond the end of the map count as used.
   always_comb begin
      base = EXT_W'(ev_ptr_ff) << LOG_W;
      word = rd_data & {WORD_W{rvalid_ff}};
      for (int b = 0; b < WORD_W; b++) begin
         eff_used[b] = word[b] | !((base + EXT_W'(b)) < NUM_X);
         mask[b]     = ((base + EXT_W'(b)) >= lo_ff) && ((base + EXT_W'(b)) <= hi_ff);
      end
   end

   // Free run ending at each bit, from the last used bit at or below it.
   always_comb begin
      logic           found;
      logic [LOG_W-1:0] jj;
      found = 1'b0;
      jj    = '0;
      for (int i = 0; i < WORD_W; i++) begin
         found = 1'b0;
         jj    = '0;
         for (int j = 0; j < WORD_W; j++) begin
            if (j <= i && eff_used[j]) begin
               found = 1'b1;
               jj    = LOG_W'(j);
            end
         end
         if (found) begin
            run_a[i]   = EXT_W'(i) - EXT_W'(jj);
            begin_a[i] = base + EXT_W'(jj) + EXT_W'(1);
         end else begin
            run_a[i]   = carry_ff + EXT_W'(i + 1);
            begin_a[i] = (carry_ff == '0) ? base : cbegin_ff;
         end
         hit[i] = run_a[i] >= EXT_W'(len_ff);
      end
   end

   // the run may start in an earlier word than the one that completes it
   always_comb begin
      hit_any   = |hit;
      hit_begin = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_begin = begin_a[i];
         end
      end
      alloc_hi    = hit_begin + EXT_W'(len_ff) - EXT_W'(1);
      alloc_sh    = alloc_hi >> LOG_W;
      alloc_lo_sh = hit_begin >> LOG_W;
   end

   assign wr_data = op_set_ff ? (word | mask) : (word & ~mask);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ev_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ev_vld_ff    <= ev_vld_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      ev_ptr_ff     <= rd_ptr_ff;
      rvalid_ff     <= valid_ff[rd_ptr_ff];
      op_set_ff     <= op_set_in;
      len_ff        <= len_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      end_word_ff   <= end_word_in;
      carry_ff      <= carry_in;
      cbegin_ff     <= cbegin_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   always_comb begin
      state_in      = state_ff;
      rd_ptr_in     = rd_ptr_ff;
      valid_in      = valid_ff;
      op_set_in     = op_set_ff;
      len_in        = len_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      end_word_in   = end_word_ff;
      carry_in      = carry_ff;
      cbegin_in     = cbegin_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      req_tready    = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            res_status_in = STATUS_OK;
            res_start_in  = '0;
            if (req_tvalid) begin
               case (req_func)
                  FN_ALLOC: begin
                     len_in    = req_len;
                     carry_in  = '0;
                     cbegin_in = '0;
                     rd_ptr_in = '0;
                     op_set_in = 1'b1;
                     if (req_len == '0) begin
                        res_status_in = STATUS_FAIL;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FN_FREE: begin
                     op_set_in   = 1'b0;
                     lo_in       = EXT_W'(req_first);
                     hi_in       = free_hi;
                     rd_ptr_in   = free_sh[WAW-1:0];
                     end_word_in = hi_sh[WAW-1:0];
                     if (req_len == '0 || EXT_W'(req_first) >= NUM_X) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_MARK;
                     end
                  end
                  FN_CLEAR: begin
                     valid_in = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     res_status_in = STATUS_FAIL;
                     state_in      = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            rd_en     = 1'b1;
            rd_ptr_in = (rd_ptr_ff == LAST_W) ? rd_ptr_ff : rd_ptr_ff + WAW'(1);
            if (ev_vld_ff) begin
               carry_in  = run_a[WORD_W-1];
               cbegin_in = begin_a[WORD_W-1];
               if (hit_any) begin
                  lo_in        = hit_begin;
                  hi_in        = alloc_hi;
                  end_word_in  = alloc_sh[WAW-1:0];
                  rd_ptr_in    = alloc_lo_sh[WAW-1:0];
                  res_start_in = hit_begin[START_W-1:0];
                  state_in     = ST_MARK;
               end else if (ev_ptr_ff == LAST_W) begin
                  res_status_in = STATUS_FAIL;
                  state_in      = ST_DONE;
               end
            end
         end

         ST_MARK: begin
            rd_en     = 1'b1;
            rd_ptr_in = (rd_ptr_ff == end_word_ff) ? rd_ptr_ff : rd_ptr_ff + WAW'(1);
            if (ev_vld_ff) begin
               wr_en               = 1'b1;
               valid_in[ev_ptr_ff] = 1'b1;
               if (ev_ptr_ff == end_word_ff) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a word read is evaluated only if it was issued in the state we remain in
   assign ev_vld_in = rd_en && (state_in == state_ff);

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_status_ff;
   assign rsp_tdata    = {{(16 - START_W){1'b0}}, rsp_start_ff};

   // a failed result never carries a start sector
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_FAIL |-> rsp_start_ff == '0)
      else $error("failed result with non-zero start sector");

   // marking never writes past the last word of its range
   a_mark_bound: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ev_ptr_ff <= end_word_ff)
      else $error("map write beyond end of range");

   // a clear request leaves every map word reading as free
   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_func == FN_CLEAR |=> valid_ff == '0)
      else $error("clear did not drop word valid bits");

endmodule

`default_nettype wire

/* sim/tb_bitmap_contiguous_sector_allocator_unit.sv */
// Self-checking bench for the first-fit contiguous sector allocator: a queued stream driver,
// a stalling response monitor and an in-bench used-map predictor; every result word is checked.
// Depends on bcsa_pkg and the allocator RTL only.
`default_nettype none

module tb_bitmap_contiguous_sector_allocator_unit;
   import bcsa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SECTORS     = 1024;
   localparam int RANDOM_REQS = 900;

   typedef struct packed {
      func_type           func;
      logic [FIRST_W-1:0] first;
      logic [RUN_W-1:0]   len;
   } sector_req_t;

   typedef struct packed {
      logic               status;
      logic [START_W-1:0] run_start;
   } sector_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;   // [1:0] func
   logic [23:0] req_tdata = '0;   // [9:0] first_sector, [20:10] run_length, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [0:0]  rsp_tuser;        // [0] status
   logic [15:0] rsp_tdata;        // [9:0] run_start, rest zero

   bitmap_contiguous_sector_allocator_unit #(.NUM_SECTORS(SECTORS)) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   sector_req_t pending_requests[$];
   sector_rsp_t pending_results[$];
   bit [SECTORS-1:0] used_map = '0;

   int queued_count = 0;
   int accepted_count = 0;
   int result_count = 0;
   int mismatches = 0;
   int n_alloc = 0, n_alloc_refused = 0, n_free = 0, n_clear = 0, n_unknown = 0;

   // first-fit search and map update for one request
   function automatic sector_rsp_t apply_to_map(input sector_req_t r);
      sector_rsp_t res;
      int run_len;
      int run_base;
      int s;
      bit found;
      res.status = STATUS_FAIL;
      res.run_start = '0;
      case (r.func)
         FN_ALLOC: begin
            run_len = 0;
            run_base = 0;
            found = 1'b0;
            if (r.len != 0) begin
               for (s = 0; s < SECTORS && !found; s++) begin
                  if (!used_map[s]) begin
                     if (run_len == 0) run_base = s;
                     run_len++;
                     if (run_len == int'(r.len)) found = 1'b1;
                  end else begin
                     run_len = 0;
                  end
               end
            end
            if (found) begin
               for (s = run_base; s < run_base + int'(r.len); s++) used_map[s] = 1'b1;
               res.status = STATUS_OK;
               res.run_start = START_W'(run_base);
            end
         end
         FN_FREE: begin
            for (s = int'(r.first); s < int'(r.first) + int'(r.len) && s < SECTORS; s++)
               used_map[s] = 1'b0;
            res.status = STATUS_OK;
         end
         FN_CLEAR: begin
            used_map = '0;
            res.status = STATUS_OK;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic queue_req(input func_type f, input int first, input int len);
      sector_req_t r;
      r.func = f;
      r.first = FIRST_W'(first);
      r.len = RUN_W'(len);
      pending_requests.push_back(r);
      queued_count++;
   endtask

   // driver: bursts of words with random gaps; prediction happens on acceptance
   sector_req_t cur_req;
   sector_rsp_t predicted;
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tuser <= '0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted = apply_to_map(cur_req);
            pending_results.push_back(predicted);
            accepted_count++;
            case (cur_req.func)
               FN_ALLOC: begin
                  n_alloc++;
                  if (predicted.status == STATUS_FAIL) n_alloc_refused++;
               end
               FN_FREE:  n_free++;
               FN_CLEAR: n_clear++;
               default:  n_unknown++;
            endcase
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               cur_req = pending_requests.pop_front();
               req_tuser <= cur_req.func;
               req_tdata <= {3'b000, cur_req.len, cur_req.first};
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure: cycles through ready, alternate, light and heavy stalls
   logic [9:0] rx_cycle = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_cycle <= '0;
      end else begin
         rx_cycle <= rx_cycle + 1'b1;
         case (rx_cycle[9:8])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= rx_cycle[0];
            2'd2: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // monitor
   sector_rsp_t want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected result word: status %0b run_start %0d",
                        $realtime, rsp_tuser[0], rsp_tdata[9:0]);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser[0] !== want.status || rsp_tdata[9:0] !== want.run_start) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] result %0d: expected status %0b run_start %0d, got %0b %0d",
                           $realtime, result_count, want.status, want.run_start,
                           rsp_tuser[0], rsp_tdata[9:0]);
            end
         end
      end
   end

   int pick;

   initial begin
      // directed: zero count, no fit, word crossings, hole reuse, free past end,
      // unknown operation, clear, full map, refree of free sectors
      queue_req(FN_ALLOC, 0, 0);
      queue_req(FN_ALLOC, 0, 1);
      queue_req(FN_ALLOC, 0, 1024);
      queue_req(FN_ALLOC, 1023, 2047);
      queue_req(FN_FREE, 0, 0);
      queue_req(FN_ALLOC, 0, 31);
      queue_req(FN_ALLOC, 0, 33);
      queue_req(FN_FREE, 10, 5);
      queue_req(FN_ALLOC, 0, 6);
      queue_req(FN_ALLOC, 0, 5);
      queue_req(FN_FREE, 1023, 2047);
      queue_req(func_type'(2'd3), 1023, 2047);
      queue_req(FN_CLEAR, 1023, 1024);
      queue_req(FN_ALLOC, 0, 1024);
      queue_req(FN_ALLOC, 0, 1);
      queue_req(FN_FREE, 1000, 100);
      queue_req(FN_ALLOC, 0, 24);
      queue_req(FN_FREE, 512, 1);
      queue_req(FN_ALLOC, 0, 1);
      queue_req(FN_FREE, 0, 1024);
      queue_req(FN_FREE, 0, 1024);
      queue_req(FN_ALLOC, 0, 1023);
      queue_req(FN_ALLOC, 0, 1);
      queue_req(FN_ALLOC, 0, 1);
      queue_req(FN_CLEAR, 0, 0);

      // random: mostly allocate/free traffic that fragments the map, with some noise
      for (int i = 0; i < RANDOM_REQS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            if ($urandom_range(0, 99) < 85)
               queue_req(FN_ALLOC, $urandom_range(0, 1023), $urandom_range(1, 32));
            else if ($urandom_range(0, 9) < 8)
               queue_req(FN_ALLOC, $urandom_range(0, 1023), $urandom_range(33, 200));
            else
               queue_req(FN_ALLOC, $urandom_range(0, 1023), $urandom_range(201, 1024));
         end else if (pick < 88) begin
            queue_req(FN_FREE, $urandom_range(0, 1023), $urandom_range(1, 96));
         end else if (pick < 90) begin
            queue_req(FN_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 2047));
         end else if (pick < 93) begin
            queue_req(func_type'(2'd3), $urandom_range(0, 1023), $urandom_range(0, 2047));
         end else begin
            queue_req(func_type'($urandom_range(0, 1)), $urandom_range(0, 1023),
                      $urandom_range(0, 2047));
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (accepted_count != queued_count || pending_results.size() != 0);
      repeat (100) @(negedge clock);

      $display("Ran %0d requests: %0d allocations (%0d refused), %0d frees, %0d clears,",
               accepted_count, n_alloc, n_alloc_refused, n_free, n_clear);
      $display("%0d unknown operations; %0d result words checked, %0d mismatches.",
               n_unknown, result_count, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("** bitmap_contiguous_sector_allocator_unit: PASSED **");
      end else begin
         $display("** bitmap_contiguous_sector_allocator_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d of %0d requests accepted.", accepted_count, queued_count);
      $display("** bitmap_contiguous_sector_allocator_unit: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
